[hw/rtl/vgd_pkg.sv]
`default_nettype none

package vgd_pkg;

    // Table size and field widths.
    localparam int MAX_CELLS  = 1024;
    localparam int IDX_W      = 10;
    localparam int USED_W     = 11;
    localparam int COUNT_BITS = 16;
    localparam int SUM_W      = 48;
    localparam int COORD_W    = 32;
    localparam int VOX_W      = 31;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;

    localparam logic [USED_W-1:0]     MAX_CELLS_U = USED_W'(MAX_CELLS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

    // Request type codes as they arrive on the input.
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_MERGED  = 3'd0;
    localparam logic [2:0] STAT_NEW     = 3'd1;
    localparam logic [2:0] STAT_FULL    = 3'd2;
    localparam logic [2:0] STAT_SAT     = 3'd3;
    localparam logic [2:0] STAT_READ_OK = 3'd4;
    localparam logic [2:0] STAT_UNUSED  = 3'd5;
    localparam logic [2:0] STAT_CLEARED = 3'd6;

    // Operation decided by the front part.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_READ,
        OP_CLEAR,
        OP_BAD
    } op_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        op_t                         op;
        logic [2:0][COORD_W-1:0]     point;
        logic [IDX_W-1:0]            cell_index;
    } req_t;

    // One table entry.
    typedef struct packed {
        logic [2:0][COORD_W-1:0]     key;
        logic [2:0][SUM_W-1:0]       sum;
        logic [COUNT_BITS-1:0]       count;
    } entry_t;

    // One result item.
    typedef struct packed {
        logic [2:0]                  status;
        logic [IDX_W-1:0]            result_index;
        logic [2:0][COORD_W-1:0]     mean;
        logic [COUNT_BITS-1:0]       point_count;
        logic [USED_W-1:0]           cells_used;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/vgd_front.sv]
`default_nettype none

module vgd_front
    import vgd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            in_req_type,
    input  wire logic [2:0][COORD_W-1:0] in_point,
    input  wire logic [IDX_W-1:0]      in_cell_index,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output req_t                       q_item
);

    req_t                  queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W:0]       fill_reg;
    logic                  push;
    logic                  pop;
    op_t                   op_dec;

    // Classify the request type.
    always_comb begin
        case (in_req_type)
            REQ_ADD:   op_dec = OP_ADD;
            REQ_READ:  op_dec = OP_READ;
            REQ_CLEAR: op_dec = OP_CLEAR;
            default:   op_dec = OP_BAD;
        endcase
    end

    assign in_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= '{op: op_dec, point: in_point, cell_index: in_cell_index};
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vgd_div.sv]
`default_nettype none

module vgd_div
    import vgd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [SUM_W-1:0]   dividend,
    input  wire logic [VOX_W-1:0]   divisor,
    output logic                    busy,
    output logic                    done,
    output logic [SUM_W-1:0]        quotient,
    output logic                    rem_nz
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]   quo_reg;
    logic [VOX_W-1:0]   rem_reg;
    logic [VOX_W-1:0]   dsr_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [VOX_W:0]     trial;
    logic               fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[SUM_W-2:0], fits};
                rem_reg <= fits ? VOX_W'(trial - {1'b0, dsr_reg}) : VOX_W'(trial);
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);

endmodule

`default_nettype wire

[hw/rtl/vgd_back.sv]
`default_nettype none

module vgd_back
    import vgd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [VOX_W-1:0]   voxel_size,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire req_t               q_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output result_t                 out_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_SEARCH,
        S_COMMIT,
        S_RDMEM,
        S_RDCHK,
        S_RDDIV,
        S_OUTPUT
    } state_t;

    state_t                      state_reg;
    req_t                        req_reg;
    logic [USED_W-1:0]           used_reg;
    logic [2:0][COORD_W-1:0]     key_reg;
    logic [USED_W-1:0]           scan_reg;
    logic [IDX_W-1:0]            chk_idx_reg;
    logic                        pend_reg;
    logic                        hit_reg;
    logic [IDX_W-1:0]            hit_idx_reg;
    entry_t                      entry_reg;
    result_t                     res_reg;
    result_t                     m_item_reg;
    logic                        m_valid_reg;

    entry_t                      table_mem [MAX_CELLS];
    entry_t                      rdata_reg;
    logic [IDX_W-1:0]            raddr;
    logic                        we;
    logic [IDX_W-1:0]            waddr;
    entry_t                      wdata;

    logic                        div_start;
    logic [2:0][COORD_W-1:0]     pt_mag;
    logic [2:0][SUM_W-1:0]       div_dvd;
    logic [VOX_W-1:0]            div_dsr;
    logic [2:0]                  div_busy;
    logic [2:0]                  div_done;
    logic [2:0][SUM_W-1:0]       div_quo;
    logic [2:0]                  div_rnz;
    logic [VOX_W-1:0]            vox_eff;
    logic                        key_match;
    logic                        rd_ok;
    logic                        out_free;

    assign vox_eff   = (voxel_size == '0) ? VOX_W'(1) : voxel_size;
    assign key_match = (rdata_reg.key == key_reg);
    assign rd_ok     = ({1'b0, req_reg.cell_index} < used_reg) && (rdata_reg.count != '0);
    assign out_free  = !m_valid_reg || out_ready;
    assign q_ready   = (state_reg == S_IDLE);
    assign raddr     = (state_reg == S_RDMEM) ? req_reg.cell_index : scan_reg[IDX_W-1:0];

    // Divider lane operands: point magnitudes for an add, sum magnitudes for a read.
    always_comb begin
        div_start = 1'b0;
        div_dsr   = vox_eff;
        for (int k = 0; k < 3; k++) begin
            pt_mag[k]  = q_item.point[k][COORD_W-1] ? (~q_item.point[k] + 1'b1)
                                                    : q_item.point[k];
            div_dvd[k] = {{(SUM_W-COORD_W){1'b0}}, pt_mag[k]};
        end
        if (state_reg == S_IDLE && q_valid && q_item.op == OP_ADD) begin
            div_start = 1'b1;
        end else if (state_reg == S_RDCHK && rd_ok) begin
            div_start = 1'b1;
            div_dsr   = VOX_W'(rdata_reg.count);
            for (int k = 0; k < 3; k++) begin
                div_dvd[k] = rdata_reg.sum[k][SUM_W-1] ? (~rdata_reg.sum[k] + 1'b1)
                                                       : rdata_reg.sum[k];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        vgd_div u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (div_dvd[g]),
            .divisor  (div_dsr),
            .busy     (div_busy[g]),
            .done     (div_done[g]),
            .quotient (div_quo[g]),
            .rem_nz   (div_rnz[g])
        );
    end

    // Table write for a merge or a new cell.
    always_comb begin
        we    = 1'b0;
        waddr = hit_idx_reg;
        wdata = entry_reg;
        if (state_reg == S_COMMIT) begin
            if (hit_reg) begin
                we = (entry_reg.count != COUNT_MAX);
                for (int k = 0; k < 3; k++) begin
                    wdata.sum[k] = entry_reg.sum[k]
                                 + {{(SUM_W-COORD_W){req_reg.point[k][COORD_W-1]}},
                                    req_reg.point[k]};
                end
                wdata.count = entry_reg.count + 1'b1;
            end else begin
                we        = (used_reg != MAX_CELLS_U);
                waddr     = used_reg[IDX_W-1:0];
                wdata.key = key_reg;
                for (int k = 0; k < 3; k++) begin
                    wdata.sum[k] = {{(SUM_W-COORD_W){req_reg.point[k][COORD_W-1]}},
                                    req_reg.point[k]};
                end
                wdata.count = COUNT_BITS'(1);
            end
        end
    end

    // Cell table, one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            table_mem[waddr] <= wdata;
        end
        rdata_reg <= table_mem[raddr];
    end

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            res_reg     <= '0;
        end else begin
            // The output state loads a new item itself whenever the register is free.
            if (m_valid_reg && out_ready && state_reg != S_OUTPUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        req_reg <= q_item;
                        case (q_item.op)
                            OP_ADD: begin
                                state_reg <= S_DIVIDE;
                            end
                            OP_READ: begin
                                state_reg <= S_RDMEM;
                            end
                            OP_CLEAR: begin
                                used_reg            <= '0;
                                res_reg.status      <= STAT_CLEARED;
                                res_reg.cells_used  <= '0;
                                state_reg           <= S_OUTPUT;
                            end
                            default: begin
                                res_reg.status       <= STAT_UNUSED;
                                res_reg.result_index <= q_item.cell_index;
                                res_reg.cells_used   <= used_reg;
                                state_reg            <= S_OUTPUT;
                            end
                        endcase
                    end
                end
                S_DIVIDE: begin
                    if (&div_done) begin
                        // Floor: a negative point with a remainder steps one further down.
                        for (int k = 0; k < 3; k++) begin
                            key_reg[k] <= req_reg.point[k][COORD_W-1]
                                ? (~div_quo[k][COORD_W-1:0] + 1'b1
                                   - COORD_W'(div_rnz[k]))
                                : div_quo[k][COORD_W-1:0];
                        end
                        scan_reg <= '0;
                        pend_reg <= 1'b0;
                        hit_reg  <= 1'b0;
                        state_reg <= (used_reg == '0) ? S_COMMIT : S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // Reads are issued one a cycle; each is compared in the next cycle.
                    if (pend_reg && key_match) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= chk_idx_reg;
                        entry_reg   <= rdata_reg;
                        state_reg   <= S_COMMIT;
                    end else if (pend_reg && ({1'b0, chk_idx_reg} + 1'b1 == used_reg)) begin
                        state_reg <= S_COMMIT;
                    end else begin
                        chk_idx_reg <= scan_reg[IDX_W-1:0];
                        pend_reg    <= 1'b1;
                        scan_reg    <= scan_reg + 1'b1;
                    end
                end
                S_COMMIT: begin
                    if (hit_reg) begin
                        res_reg.result_index <= hit_idx_reg;
                        if (entry_reg.count == COUNT_MAX) begin
                            res_reg.status      <= STAT_SAT;
                            res_reg.point_count <= entry_reg.count;
                        end else begin
                            res_reg.status      <= STAT_MERGED;
                            res_reg.point_count <= entry_reg.count + 1'b1;
                        end
                        res_reg.cells_used <= used_reg;
                    end else if (used_reg == MAX_CELLS_U) begin
                        res_reg.status     <= STAT_FULL;
                        res_reg.cells_used <= used_reg;
                    end else begin
                        res_reg.status       <= STAT_NEW;
                        res_reg.result_index <= used_reg[IDX_W-1:0];
                        res_reg.point_count  <= COUNT_BITS'(1);
                        res_reg.cells_used   <= used_reg + 1'b1;
                        used_reg             <= used_reg + 1'b1;
                    end
                    state_reg <= S_OUTPUT;
                end
                S_RDMEM: begin
                    state_reg <= S_RDCHK;
                end
                S_RDCHK: begin
                    res_reg.result_index <= req_reg.cell_index;
                    res_reg.cells_used   <= used_reg;
                    if (rd_ok) begin
                        entry_reg <= rdata_reg;
                        state_reg <= S_RDDIV;
                    end else begin
                        res_reg.status <= STAT_UNUSED;
                        state_reg      <= S_OUTPUT;
                    end
                end
                S_RDDIV: begin
                    if (&div_done) begin
                        for (int k = 0; k < 3; k++) begin
                            res_reg.mean[k] <= entry_reg.sum[k][SUM_W-1]
                                ? (~div_quo[k][COORD_W-1:0] + 1'b1)
                                : div_quo[k][COORD_W-1:0];
                        end
                        res_reg.status      <= STAT_READ_OK;
                        res_reg.point_count <= entry_reg.count;
                        state_reg           <= S_OUTPUT;
                    end
                end
                S_OUTPUT: begin
                    // Hand the result over and start the next item from a clean result.
                    if (out_free) begin
                        m_item_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        res_reg     <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = m_valid_reg;
    assign out_item  = m_item_reg;

    // The occupancy never passes the table size.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= MAX_CELLS_U)
        else $error("cell occupancy beyond table size");

    // A new cell raises the occupancy by exactly one.
    a_new_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COMMIT && !hit_reg && used_reg != MAX_CELLS_U)
        |=> used_reg == $past(used_reg) + 1'b1)
        else $error("new cell did not advance occupancy");

    // The dividers are never restarted while still running.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (div_busy == '0))
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

[hw/rtl/voxel_grid_downsample_unit.sv]
`default_nettype none

// An add runs 48 divider steps, then compares one table entry per cycle (none with an empty
// table); a read runs 48 divider steps for the mean; a read of an unused index, a clear or an
// unknown request skips the dividers. Items are worked one at a time; the next can start the
// cycle after a result is registered. A four-item input queue and an output register let both
// sides stall independently. Reset (aresetn low, synchronous) empties the table and the queue
// and sets the voxel size to 1.0; table contents need no clearing pass.
module voxel_grid_downsample_unit
    import vgd_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic [30:0]    cfg_wr_data,  // voxel_size
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [111:0]   s_tdata,      // point_x, point_y, point_z, cell_index
    input  wire logic [1:0]     s_tuser,      // req_type
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [135:0]        m_tdata,      // result_index, mean_x, mean_y, mean_z,
                                              // point_count, cells_used
    output logic [2:0]          m_tuser       // status
);

    logic [VOX_W-1:0]        voxel_size_reg;
    logic                    q_valid;
    logic                    q_ready;
    req_t                    q_item;
    result_t                 res;
    logic [2:0][COORD_W-1:0] in_point;

    // Voxel size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voxel_size_reg <= VOX_W'(65536);
        end else if (cfg_wr_en) begin
            voxel_size_reg <= cfg_wr_data;
        end
    end

    assign in_point[0] = s_tdata[31:0];
    assign in_point[1] = s_tdata[63:32];
    assign in_point[2] = s_tdata[95:64];

    vgd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_req_type   (s_tuser),
        .in_point      (in_point),
        .in_cell_index (s_tdata[105:96]),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    vgd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .voxel_size (voxel_size_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (res)
    );

    // Result packing, lowest field first.
    assign m_tuser = res.status;
    assign m_tdata = {3'b000, res.cells_used, res.point_count,
                      res.mean[2], res.mean[1], res.mean[0], res.result_index};

endmodule

`default_nettype wire
